>>> src/fpr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fpr_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int IDX_W = $clog2(MAX_PAYLOAD + 1);
    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    localparam logic [7:0] RESET_START_BYTE = 8'h02;
    localparam logic [7:0] RESET_END_BYTE = 8'h03;

    localparam logic REG_START_BYTE = 1'b0;
    localparam logic REG_END_BYTE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CHECKSUM = 2'd1,
        ST_END      = 2'd2,
        ST_LENGTH   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN,
        PH_DATA,
        PH_CHK,
        PH_END,
        PH_RD,
        PH_EMIT
    } phase_t;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] end_byte;
    } cfg_t;

endpackage

`default_nettype wire

>>> src/framed_packet_receiver_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake            Payload
// in        in_valid, in_ready   rx_byte
// out       out_valid, out_ready payload_byte, frame_status, last_of_frame
// cfg       APB write/read       start_byte at 0x0, end_byte at 0x4
//
// Input is refused while the store is drained; the length, checksum and end
// bytes also wait while an earlier result is still held in the output register
// and out_ready is low. After a good frame the payload store is drained one
// byte at a time (a store read, then the load of the output register), and
// the drain stalls while out_ready is low.
// Reset is asynchronous and clears the control state; the store is not cleared.

module framed_packet_receiver_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       payload_byte,
    output logic [1:0]       frame_status,
    output logic             last_of_frame,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import fpr_pkg::*;

    cfg_t               cfg;
    phase_t             phase_reg;
    phase_t             phase_next;
    logic [IDX_W-1:0]   wr_idx_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic [IDX_W-1:0]   len_reg;
    logic [7:0]         xor_reg;
    logic               out_valid_reg;
    logic [7:0]         out_byte_reg;
    status_t            out_status_reg;
    logic               out_last_reg;

    logic               accept;
    logic               out_free;
    logic               bad_len;
    logic               clr;
    logic               len_ld;
    logic               wr_en;
    logic               rd_en;
    logic               rd_inc;
    logic               load;
    logic [7:0]         load_byte;
    status_t            load_status;
    logic               load_last;
    logic [7:0]         rd_data;

    fpr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fpr_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_idx_reg[ADDR_W-1:0]),
        .wr_data (rx_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    assign accept = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign bad_len = (rx_byte == 8'd0) || (rx_byte > 8'(MAX_PAYLOAD));

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HUNT:
            begin
                if (accept && rx_byte == cfg.start_byte)
                begin
                    phase_next = PH_LEN;
                end
            end
            PH_LEN:
            begin
                if (accept)
                begin
                    phase_next = bad_len ? PH_HUNT : PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (accept && (wr_idx_reg + IDX_W'(1)) == len_reg)
                begin
                    phase_next = PH_CHK;
                end
            end
            PH_CHK:
            begin
                if (accept)
                begin
                    phase_next = (rx_byte != xor_reg) ? PH_HUNT : PH_END;
                end
            end
            PH_END:
            begin
                if (accept)
                begin
                    phase_next = (rx_byte != cfg.end_byte) ? PH_HUNT : PH_RD;
                end
            end
            PH_RD:
            begin
                phase_next = PH_EMIT;
            end
            PH_EMIT:
            begin
                if (out_free)
                begin
                    phase_next = ((rd_idx_reg + IDX_W'(1)) == wr_idx_reg) ? PH_HUNT : PH_RD;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        clr = 1'b0;
        len_ld = 1'b0;
        wr_en = 1'b0;
        rd_en = 1'b0;
        rd_inc = 1'b0;
        load = 1'b0;
        load_byte = 8'd0;
        load_status = ST_OK;
        load_last = 1'b1;
        unique case (phase_reg)
            PH_HUNT:
            begin
                in_ready = 1'b1;
                clr = accept && (rx_byte == cfg.start_byte);
            end
            PH_LEN:
            begin
                in_ready = out_free;
                len_ld = accept && !bad_len;
                load = accept && bad_len;
                load_status = ST_LENGTH;
            end
            PH_DATA:
            begin
                in_ready = 1'b1;
                wr_en = accept;
            end
            PH_CHK:
            begin
                in_ready = out_free;
                load = accept && (rx_byte != xor_reg);
                load_status = ST_CHECKSUM;
            end
            PH_END:
            begin
                in_ready = out_free;
                load = accept && (rx_byte != cfg.end_byte);
                load_status = ST_END;
            end
            PH_RD:
            begin
                rd_en = 1'b1;
            end
            PH_EMIT:
            begin
                load = out_free;
                rd_inc = out_free;
                load_byte = rd_data;
                load_status = ST_OK;
                load_last = (rd_idx_reg + IDX_W'(1)) == wr_idx_reg;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            len_reg <= '0;
            xor_reg <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (clr)
            begin
                wr_idx_reg <= '0;
                rd_idx_reg <= '0;
                xor_reg <= 8'd0;
            end
            else
            begin
                if (wr_en)
                begin
                    wr_idx_reg <= wr_idx_reg + IDX_W'(1);
                    xor_reg <= xor_reg ^ rx_byte;
                end
                if (rd_inc)
                begin
                    rd_idx_reg <= rd_idx_reg + IDX_W'(1);
                end
            end
            if (len_ld)
            begin
                len_reg <= IDX_W'(rx_byte);
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= load_byte;
            out_status_reg <= load_status;
            out_last_reg <= load_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign payload_byte = out_byte_reg;
    assign frame_status = out_status_reg;
    assign last_of_frame = out_last_reg;

    a_no_input_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (phase_reg != PH_RD && phase_reg != PH_EMIT))
        else $error("input taken while the store is being drained");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_idx_reg <= IDX_W'(MAX_PAYLOAD))
        else $error("write index beyond the store depth");

    a_read_below_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_RD || phase_reg == PH_EMIT) |-> rd_idx_reg < wr_idx_reg)
        else $error("store read beyond the bytes of the frame");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !load)
        else $error("held result overwritten");

endmodule

`default_nettype wire

>>> src/fpr_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module fpr_regs (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output fpr_pkg::cfg_t      cfg
);
    import fpr_pkg::*;

    logic [7:0] start_byte_reg;
    logic [7:0] end_byte_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= RESET_START_BYTE;
            end_byte_reg <= RESET_END_BYTE;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_START_BYTE)
            begin
                start_byte_reg <= pwdata[7:0];
            end
            else
            begin
                end_byte_reg <= pwdata[7:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_START_BYTE)
        begin
            prdata = {24'd0, start_byte_reg};
        end
        else
        begin
            prdata = {24'd0, end_byte_reg};
        end
    end

    assign cfg.start_byte = start_byte_reg;
    assign cfg.end_byte = end_byte_reg;

endmodule

`default_nettype wire

>>> src/fpr_store.sv
`timescale 1ns / 1ps
`default_nettype none

module fpr_store (
    input  wire logic                        clk,
    input  wire logic                        wr_en,
    input  wire logic [fpr_pkg::ADDR_W-1:0]  wr_addr,
    input  wire logic [7:0]                  wr_data,
    input  wire logic                        rd_en,
    input  wire logic [fpr_pkg::ADDR_W-1:0]  rd_addr,
    output logic [7:0]                       rd_data
);
    import fpr_pkg::*;

    logic [7:0] mem [MAX_PAYLOAD];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire
